// File: sv/nls_pkg.sv
// Shared types and constants for the numeric literal scanner.
package nls_pkg;

  localparam int unsigned LIT_MAX_LEN = 1024;
  localparam int unsigned CNT_W = 11;

  localparam logic [CNT_W-1:0] LIM_DEC = CNT_W'(LIT_MAX_LEN - 1);
  localparam logic [CNT_W-1:0] LIM_RAD = CNT_W'(LIT_MAX_LEN);

  localparam logic [1:0] KIND_DEC = 2'd0;
  localparam logic [1:0] KIND_OCT = 2'd1;
  localparam logic [1:0] KIND_HEX = 2'd2;
  localparam logic [1:0] KIND_BIN = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ZERO,
    PH_DEC,
    PH_HEX,
    PH_BIN,
    PH_SUF_DEC,
    PH_SUF_HEX,
    PH_SUF_BIN
  } nls_phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       start_req;
  } nls_in_t;

  typedef struct packed {
    logic [31:0]      value;
    logic [1:0]       kind;
    logic             has_dot;
    logic             is_long;
    logic             is_unsigned;
    logic             ch_taken;
    logic             too_long;
    logic [CNT_W-1:0] length;
  } nls_out_t;

  // classified character
  typedef struct packed {
    logic       start;
    logic [3:0] dig;
    logic       dec_ok;
    logic       hex_ok;
    logic       bin_ok;
    logic       is_zero;
    logic       is_dot;
    logic       is_l;
    logic       is_u;
    logic       is_x;
    logic       is_b;
  } nls_class_t;

  typedef struct packed {
    logic oct;
    logic dot;
    logic dot2;
    logic lng;
    logic uns;
  } nls_flags_t;

endpackage

// File: sv/nls_front.sv
// Front end: decodes each text byte into character classes and a digit value.
module nls_front (
  input  nls_pkg::nls_in_t    in_data,
  output nls_pkg::nls_class_t cls
);
  import nls_pkg::*;

  logic [7:0] c;
  logic       is_dec;
  logic       is_lo_hex;
  logic       is_up_hex;

  assign c         = in_data.ch;
  assign is_dec    = (c >= 8'h30) && (c <= 8'h39);
  assign is_lo_hex = (c >= 8'h61) && (c <= 8'h66);
  assign is_up_hex = (c >= 8'h41) && (c <= 8'h46);

  always_comb begin
    cls.start   = in_data.start_req;
    cls.dec_ok  = is_dec;
    cls.hex_ok  = is_dec || is_lo_hex || is_up_hex;
    cls.bin_ok  = (c == 8'h30) || (c == 8'h31);
    cls.is_zero = (c == 8'h30);
    cls.is_dot  = (c == 8'h2e);
    cls.is_l    = (c == 8'h6c) || (c == 8'h4c);
    cls.is_u    = (c == 8'h75) || (c == 8'h55);
    cls.is_x    = (c == 8'h78) || (c == 8'h58);
    cls.is_b    = (c == 8'h62) || (c == 8'h42);
    if (is_lo_hex) begin
      cls.dig = 4'(c - 8'h57);
    end else if (is_up_hex) begin
      cls.dig = 4'(c - 8'h37);
    end else begin
      cls.dig = c[3:0];
    end
  end

endmodule

// File: sv/nls_queue.sv
// Two-word queue between the classifier and the scanner.
module nls_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  nls_pkg::nls_class_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                q_valid,
  output nls_pkg::nls_class_t q_data
);
  import nls_pkg::*;

  nls_class_t mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       do_push;
  logic       do_pop;

  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_data  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: sv/nls_back.sv
// Back end: literal scanning state machine, value accumulators and result register.
module nls_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  nls_pkg::nls_class_t q_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output nls_pkg::nls_out_t   out_data
);
  import nls_pkg::*;

  nls_phase_t       phase_r, phase_nxt, phase_w;
  logic [31:0]      dec_r, dec_nxt, dec_w;
  logic [31:0]      oct_r, oct_nxt, oct_w;
  logic [31:0]      rad_r, rad_nxt, rad_w;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_w;
  nls_flags_t       flags_r, flags_nxt, flags_w;
  logic             suf_r, suf_nxt, suf_w;
  logic             emit;
  logic             taken;
  logic             err;
  nls_out_t         res;
  logic             out_valid_r;
  nls_out_t         out_data_r;

  assign pop       = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // next state
  always_comb begin
    logic go_dec;
    logic go_rad;
    logic go_suf;
    logic chk_dec;
    logic chk_rad;
    logic take;

    go_dec  = 1'b0;
    go_rad  = 1'b0;
    go_suf  = 1'b0;
    chk_dec = 1'b0;
    chk_rad = 1'b0;
    take    = 1'b0;
    emit    = 1'b0;
    taken   = 1'b0;
    err     = 1'b0;

    if (q_data.start) begin
      phase_w = PH_IDLE;
      dec_w   = '0;
      oct_w   = '0;
      rad_w   = '0;
      cnt_w   = '0;
      flags_w = '0;
      suf_w   = 1'b0;
    end else begin
      phase_w = phase_r;
      dec_w   = dec_r;
      oct_w   = oct_r;
      rad_w   = rad_r;
      cnt_w   = cnt_r;
      flags_w = flags_r;
      suf_w   = suf_r;
    end

    if (q_data.start) begin
      if (q_data.is_zero) begin
        flags_w.oct = 1'b1;
        cnt_w       = CNT_W'(1);
        phase_w     = PH_ZERO;
      end else begin
        go_dec = 1'b1;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: ;
        PH_ZERO: begin
          if (q_data.is_x || q_data.is_b) begin
            flags_w = '0;
            cnt_w   = CNT_W'(2);
            phase_w = q_data.is_x ? PH_HEX : PH_BIN;
          end else begin
            go_dec = 1'b1;
          end
        end
        PH_DEC: go_dec = 1'b1;
        PH_HEX, PH_BIN: go_rad = 1'b1;
        PH_SUF_DEC, PH_SUF_HEX, PH_SUF_BIN: go_suf = 1'b1;
        default: ;
      endcase
    end

    if (go_dec) begin
      phase_w = PH_DEC;
      if (q_data.is_dot) begin
        if (flags_w.dot) begin
          flags_w.dot2 = 1'b1;
        end
        flags_w.dot = 1'b1;
        cnt_w       = cnt_w + CNT_W'(1);
        chk_dec     = 1'b1;
      end else if (q_data.dec_ok) begin
        if (q_data.dig >= 4'd8) begin
          flags_w.oct = 1'b0;
        end
        if (!flags_w.dot) begin
          dec_w = (dec_w << 3) + (dec_w << 1) + 32'(q_data.dig);
        end
        oct_w   = (oct_w << 3) + 32'(q_data.dig);
        cnt_w   = cnt_w + CNT_W'(1);
        chk_dec = 1'b1;
      end else begin
        go_suf = 1'b1;
      end
    end

    if (go_rad) begin
      if (phase_w == PH_HEX) begin
        if (q_data.hex_ok) begin
          rad_w   = (rad_w << 4) | 32'(q_data.dig);
          cnt_w   = cnt_w + CNT_W'(1);
          chk_rad = 1'b1;
        end else begin
          go_suf = 1'b1;
        end
      end else begin
        if (q_data.bin_ok) begin
          rad_w   = (rad_w << 1) | 32'(q_data.dig[0]);
          cnt_w   = cnt_w + CNT_W'(1);
          chk_rad = 1'b1;
        end else begin
          go_suf = 1'b1;
        end
      end
    end

    if (go_suf) begin
      if (q_data.is_l && !flags_w.lng) begin
        flags_w.lng = 1'b1;
        take        = 1'b1;
      end else if (q_data.is_u && !flags_w.uns && !flags_w.dot) begin
        flags_w.uns = 1'b1;
        take        = 1'b1;
      end
      if (!take) begin
        emit = 1'b1;
      end else if (suf_w) begin
        emit  = 1'b1;
        taken = 1'b1;
      end else begin
        suf_w = 1'b1;
        if (phase_w == PH_HEX) begin
          phase_w = PH_SUF_HEX;
        end else if (phase_w == PH_BIN) begin
          phase_w = PH_SUF_BIN;
        end else begin
          phase_w = PH_SUF_DEC;
        end
      end
    end

    // body length limit
    if ((chk_dec && (cnt_w >= LIM_DEC)) || (chk_rad && (cnt_w >= LIM_RAD))) begin
      emit  = 1'b1;
      taken = 1'b1;
      err   = 1'b1;
    end

    phase_nxt = emit ? PH_IDLE : phase_w;
    suf_nxt   = emit ? 1'b0 : suf_w;
    dec_nxt   = dec_w;
    oct_nxt   = oct_w;
    rad_nxt   = rad_w;
    cnt_nxt   = cnt_w;
    flags_nxt = flags_w;
  end

  // result word
  always_comb begin
    if (phase_w == PH_HEX || phase_w == PH_SUF_HEX) begin
      res.kind = KIND_HEX;
    end else if (phase_w == PH_BIN || phase_w == PH_SUF_BIN) begin
      res.kind = KIND_BIN;
    end else begin
      res.kind = flags_w.oct ? KIND_OCT : KIND_DEC;
    end
    if (err) begin
      res.value = '0;
    end else if (res.kind == KIND_HEX || res.kind == KIND_BIN) begin
      res.value = rad_w;
    end else if (flags_w.dot) begin
      res.value = flags_w.dot2 ? 32'd0 : dec_w;
    end else if (res.kind == KIND_OCT) begin
      res.value = oct_w;
    end else begin
      res.value = dec_w;
    end
    res.has_dot     = flags_w.dot;
    res.is_long     = !err && flags_w.lng;
    res.is_unsigned = !err && flags_w.uns;
    res.ch_taken    = taken;
    res.too_long    = err;
    res.length      = cnt_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      dec_r   <= '0;
      oct_r   <= '0;
      rad_r   <= '0;
      cnt_r   <= '0;
      flags_r <= '0;
      suf_r   <= 1'b0;
    end else if (pop) begin
      phase_r <= phase_nxt;
      dec_r   <= dec_nxt;
      oct_r   <= oct_nxt;
      rad_r   <= rad_nxt;
      cnt_r   <= cnt_nxt;
      flags_r <= flags_nxt;
      suf_r   <= suf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_data_r <= res;
    end
  end

endmodule

// File: sv/number_literal_scanner.sv
// Numeric literal scanner: one text byte in per word, one result word per literal.
//
// Input channel (in_valid/in_stall/in_data): one byte of source text per word,
// with start_req set on the first character of a literal. Output channel
// (out_valid/out_stall/out_data): one word when a literal ends, giving its
// value, kind, dot/long/unsigned flags, body length, too-long error and
// whether the ending character was consumed.
// Throughput: one character per cycle, sustained. A classifier decodes each
// byte into a two-word queue; the scanner takes one queued word per cycle
// whenever its result register is empty or being drained.
// Result timing: a result word is valid the cycle after the scanner takes the
// character that ends the literal; with an empty queue, an accepted byte is
// first written into the queue and then taken by the scanner from there.
// While out_stall holds a result word, the scanner takes no characters;
// the queue fills once it holds two words and in_stall rises.
// Reset (rst_n low, synchronous) empties the queue, drops the result register
// and returns the scanner to idle; characters with start_req low are ignored
// until a literal is started.
module number_literal_scanner (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  nls_pkg::nls_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output nls_pkg::nls_out_t out_data
);
  import nls_pkg::*;

  nls_class_t cls;
  nls_class_t q_data;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;

  assign in_stall = q_full;

  nls_front u_front (
    .in_data (in_data),
    .cls     (cls)
  );

  nls_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (cls),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  nls_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
